/* src/ute_pkg.sv */
// ============================================================================
// ute_pkg
// Shared types and constants of the unsorted table engine.
// ============================================================================
`default_nettype none

package ute_pkg;

    localparam int CAPACITY      = 1024;
    localparam int ELEMENT_WIDTH = 64;
    localparam int POS_W         = $clog2(CAPACITY + 1);
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 3;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_FIELDS_W   = POS_W + ELEMENT_WIDTH;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = 2 * POS_W + ELEMENT_WIDTH;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [ELEMENT_WIDTH-1:0] word_t;

    localparam pos_t CAP_POS = POS_W'(CAPACITY);
    localparam pos_t POS_ONE = POS_W'(1);
    localparam pos_t POS_TWO = POS_W'(2);

    typedef enum logic [CMD_W-1:0] {
        CMD_SEARCH = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_MODIFY = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_BAD_POS   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD_WAIT,
        S_DEL_MOVE,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t  cmd;
        pos_t  position;
        word_t value;
    } request_t;

    typedef struct packed {
        status_t status;
        pos_t    found_position;
        word_t   data_out;
        pos_t    entry_count;
    } result_t;

endpackage

`default_nettype wire

/* src/unsorted_table_engine.sv */
// ============================================================================
// unsorted_table_engine
// Unsorted word table with search, add, modify, delete and read requests.
// ============================================================================
//
//  Channel   Direction  Signals               Contents
//  s_axis    in         tvalid/tready/tdata   tdata: position, value
//                       tuser                 tuser: cmd
//  m_axis    out        tvalid/tready/tdata   tdata: found_position, data_out,
//                       tuser                        entry_count
//                                             tuser: status
//
// The engine handles one request at a time. Search and add compare one
// stored entry per cycle, walking down from the last entry through the
// table memory's single read port. Reset clears the entry count, the
// sequencer state and the output valid flag; table words are written
// before they are ever read, so the memory needs no clearing pass. A
// finished result sits in the output register, so the next request is
// taken while the sink stalls; only a second finished result waits inside
// the sequencer.
//
`default_nettype none

module unsorted_table_engine
    import ute_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,

    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata, low bit up: position (11), value (64), zero padding.
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: cmd (3).
    input  wire [CMD_W-1:0]        s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // tdata, low bit up: found_position (11), data_out (64),
    // entry_count (11), zero padding.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status (3).
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    request_t req;
    result_t  res;
    logic     res_valid;
    logic     res_ready;

    logic     ram_we;
    addr_t    ram_waddr;
    word_t    ram_wdata;
    addr_t    ram_raddr;
    word_t    ram_rdata;

    logic     out_valid_reg, out_valid_next;
    result_t  out_reg,       out_next;

    // Unpack the request.
    assign req.cmd      = cmd_t'(s_axis_tuser);
    assign req.position = s_axis_tdata[POS_W-1:0];
    assign req.value    = s_axis_tdata[IN_FIELDS_W-1:POS_W];

    ute_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ute_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEMENT_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: refilled when empty or when its result is taken.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.entry_count,
                            out_reg.data_out, out_reg.found_position};

endmodule

`default_nettype wire

/* src/ute_ram.sv */
// ============================================================================
// ute_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module ute_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/ute_ctrl.sv */
// ============================================================================
// ute_ctrl
// Sequencer: scans, reads, modifies and writes back the table memory.
// ============================================================================
`default_nettype none

module ute_ctrl
    import ute_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             req_valid,
    output logic            req_ready,
    input  request_t        req,
    output logic            res_valid,
    input  wire             res_ready,
    output result_t         res,
    output logic            ram_we,
    output addr_t           ram_waddr,
    output word_t           ram_wdata,
    output addr_t           ram_raddr,
    input  word_t           ram_rdata
);

    state_t  state_reg, state_next;
    cmd_t    cmd_reg,   cmd_next;
    pos_t    pos_reg,   pos_next;
    word_t   val_reg,   val_next;
    pos_t    count_reg, count_next;
    pos_t    scan_reg,  scan_next;
    word_t   old_reg,   old_next;
    result_t res_reg,   res_next;

    logic    hit;
    logic    req_pos_ok;
    logic    full;
    pos_t    count_m1;
    pos_t    req_pos_m1;
    pos_t    pos_m1;
    pos_t    scan_m2;

    assign hit        = (ram_rdata == val_reg);
    assign full       = (count_reg == CAP_POS);
    assign req_pos_ok = (req.position != '0) && (req.position <= count_reg);
    assign count_m1   = count_reg - POS_ONE;
    assign req_pos_m1 = req.position - POS_ONE;
    assign pos_m1     = pos_reg - POS_ONE;
    assign scan_m2    = scan_reg - POS_TWO;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.cmd)
                        CMD_SEARCH:
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        CMD_ADD:
                            state_next = (full || count_reg == '0) ? S_DONE : S_SCAN;
                        CMD_MODIFY, CMD_DELETE, CMD_READ:
                            state_next = req_pos_ok ? S_RD_WAIT : S_DONE;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit || scan_reg == POS_ONE)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT:
                state_next = (cmd_reg == CMD_DELETE) ? S_DEL_MOVE : S_DONE;
            S_DEL_MOVE:
                state_next = S_DONE;
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs, memory accesses and datapath updates.
    always_comb
    begin
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[ADDR_W-1:0];
        ram_wdata  = val_reg;
        ram_raddr  = scan_m2[ADDR_W-1:0];
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        old_next   = old_reg;
        res_next   = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                ram_raddr = (req.cmd == CMD_SEARCH || req.cmd == CMD_ADD) ?
                            count_m1[ADDR_W-1:0] : req_pos_m1[ADDR_W-1:0];
                if (req_valid)
                begin
                    cmd_next  = req.cmd;
                    pos_next  = req.position;
                    val_next  = req.value;
                    scan_next = count_reg;
                    res_next.status         = ST_OK;
                    res_next.found_position = '0;
                    res_next.data_out       = '0;
                    res_next.entry_count    = count_reg;
                    unique case (req.cmd)
                        CMD_SEARCH:
                            res_next.status = ST_NOT_FOUND;
                        CMD_ADD:
                        begin
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // Empty table: store straight away.
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = req.value;
                                count_next = POS_ONE;
                                res_next.found_position = POS_ONE;
                                res_next.entry_count    = POS_ONE;
                            end
                        end
                        CMD_MODIFY, CMD_DELETE, CMD_READ:
                        begin
                            if (!req_pos_ok)
                            begin
                                res_next.status = ST_BAD_POS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // ram_rdata holds the entry at scan_reg; the next lower one is
                // already being fetched.
                scan_next = scan_reg - POS_ONE;
                res_next.entry_count = count_reg;
                if (hit)
                begin
                    res_next.status         = (cmd_reg == CMD_ADD) ? ST_DUPLICATE : ST_OK;
                    res_next.found_position = scan_reg;
                end
                else if (scan_reg == POS_ONE)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + POS_ONE;
                        res_next.status         = ST_OK;
                        res_next.found_position = count_reg + POS_ONE;
                        res_next.entry_count    = count_reg + POS_ONE;
                    end
                    else
                    begin
                        res_next.status         = ST_NOT_FOUND;
                        res_next.found_position = '0;
                    end
                end
            end
            S_RD_WAIT:
            begin
                ram_raddr = count_m1[ADDR_W-1:0];
                old_next  = ram_rdata;
                res_next.status         = ST_OK;
                res_next.found_position = pos_reg;
                res_next.data_out       = ram_rdata;
                res_next.entry_count    = count_reg;
                if (cmd_reg == CMD_MODIFY)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_m1[ADDR_W-1:0];
                end
            end
            S_DEL_MOVE:
            begin
                // The last entry fills the hole.
                ram_we     = 1'b1;
                ram_waddr  = pos_m1[ADDR_W-1:0];
                ram_wdata  = ram_rdata;
                count_next = count_m1;
                res_next.data_out    = old_reg;
                res_next.entry_count = count_m1;
            end
            S_DONE:
                res_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        scan_reg <= scan_next;
        old_reg  <= old_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* test/tb.sv */
// ============================================================================
// tb
// Self-checking testbench for the unsorted table engine.
// ============================================================================
//
// Requests go in on s_axis and results come back on m_axis. Every accepted
// request runs through a predictor that keeps its own copy of the table and
// the entry count. The predictor works out the one result that the request
// must produce and queues it. A monitor compares each result from the block,
// field by field, with the oldest queued result.
//
// The stimulus runs in this order:
//   - a short directed block of corner cases;
//   - a long random mix of operations, kept to a small table so scans are short;
//   - a stretch with no idling on either side;
//   - a long sink stall while the source keeps offering requests.
//
// A watchdog ends the run if no handshake happens for too long.
//
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ute_pkg::*;

    // Percent of cycles in which either side idles while random idling is on.
    localparam int IDLE_PCT       = 36;
    localparam int RANDOM_ITEMS   = 460;
    localparam int STEADY_ITEMS   = 80;
    localparam int HOLD_ITEMS     = 12;
    localparam int HOLD_CYCLES    = 400;
    // The random mix turns adds into deletes above this many entries, so
    // that search and add scans stay short.
    localparam int SOFT_MAX       = 40;
    // The longest quiet spell in a correct run is the sink stall; scans of
    // the small table are far shorter. Even a full-table scan stays well
    // under this limit.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 20;
    localparam int PRINT_CAP      = 25;
    localparam int CMD_CODES      = 1 << CMD_W;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    // Predictor state: the table words and the entry count.
    word_t   tbl_words [CAPACITY];
    int      tbl_count;
    int      peak_count;

    // Results that accepted requests must produce, oldest first.
    result_t expected_results [$];

    int      error_count;
    int      request_count;
    int      result_count;
    int      status_tally [5];
    int      stall_cycles;

    // Controls shared by the test tasks and the sink process.
    bit      tx_idle_en = 1'b1;
    bit      rx_steady = 1'b0;
    bit      rx_hold_request = 1'b0;

    unsorted_table_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Returns the highest position in 1..count that holds the word, or 0 if
    // no position holds it. The scan runs from the top down, as the block's
    // scan does.
    function automatic int highest_match(word_t w);
        for (int p = tbl_count; p > 0; p--)
        begin
            if (tbl_words[p-1] == w)
                return p;
        end
        return 0;
    endfunction

    // Applies one request to the table copy and returns the expected result.
    function automatic result_t predict_table_op(request_t r);
        result_t res;
        int      hit;
        bit      pos_ok;
        int      idx;

        res.status         = ST_OK;
        res.found_position = '0;
        res.data_out       = '0;
        pos_ok = (r.position != '0) && (int'(r.position) <= tbl_count);
        idx    = int'(r.position) - 1;

        case (r.cmd)
            CMD_SEARCH:
            begin
                hit = highest_match(r.value);
                res.found_position = pos_t'(hit);
                if (hit == 0)
                    res.status = ST_NOT_FOUND;
            end
            CMD_ADD:
            begin
                if (tbl_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    hit = highest_match(r.value);
                    if (hit != 0)
                    begin
                        res.status         = ST_DUPLICATE;
                        res.found_position = pos_t'(hit);
                    end
                    else
                    begin
                        tbl_words[tbl_count] = r.value;
                        tbl_count++;
                        res.found_position = pos_t'(tbl_count);
                    end
                end
            end
            CMD_MODIFY:
            begin
                if (!pos_ok)
                    res.status = ST_BAD_POS;
                else
                begin
                    res.data_out       = tbl_words[idx];
                    tbl_words[idx]     = r.value;
                    res.found_position = r.position;
                end
            end
            CMD_DELETE:
            begin
                if (!pos_ok)
                    res.status = ST_BAD_POS;
                else
                begin
                    // The last entry moves into the hole.
                    res.data_out       = tbl_words[idx];
                    tbl_words[idx]     = tbl_words[tbl_count-1];
                    tbl_count--;
                    res.found_position = r.position;
                end
            end
            CMD_READ:
            begin
                if (!pos_ok)
                    res.status = ST_BAD_POS;
                else
                begin
                    res.data_out       = tbl_words[idx];
                    res.found_position = r.position;
                end
            end
            default:
            begin
                // Unknown commands leave the table alone and report ok.
            end
        endcase

        res.entry_count = pos_t'(tbl_count);
        if (tbl_count > peak_count)
            peak_count = tbl_count;
        status_tally[int'(res.status)]++;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------

    // Offers one request and returns at the clock edge where it is taken.
    // Valid stays high on return, so back-to-back requests need no gap.
    task automatic send_request(cmd_t cmd, pos_t position, word_t value);
        request_t r;

        r.cmd      = cmd;
        r.position = position;
        r.value    = value;
        while (tx_idle_en && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({value, position});
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(predict_table_op(r));
        request_count++;
    endtask

    // Lowers valid and waits until every queued result has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic word_t random_word();
        if ($urandom_range(0, 3) == 0)
            return word_t'($urandom_range(0, 15));
        return word_t'({$urandom, $urandom});
    endfunction

    // A position outside 1..count, from 0 up to the top of the 11-bit field.
    function automatic pos_t bad_position();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return pos_t'(tbl_count + 1);
            default: return pos_t'($urandom_range(tbl_count + 1, (1 << POS_W) - 1));
        endcase
    endfunction

    // Mostly a position that holds an entry, sometimes one that does not.
    function automatic pos_t pick_position();
        if (tbl_count == 0 || $urandom_range(0, 99) < 15)
            return bad_position();
        return pos_t'($urandom_range(1, tbl_count));
    endfunction

    function automatic word_t stored_word();
        return tbl_words[$urandom_range(0, tbl_count - 1)];
    endfunction

    // One random request drawn from a weighted mix of all operations.
    task automatic random_request();
        int    pick;
        word_t w;

        pick = $urandom_range(0, 99);
        if (pick >= 20 && pick < 45 && tbl_count > SOFT_MAX)
            pick = 60;
        if (pick < 20)
        begin
            // Search, mostly for a word that the table holds.
            if (tbl_count > 0 && $urandom_range(0, 99) < 60)
                w = stored_word();
            else
                w = random_word();
            send_request(CMD_SEARCH, pos_t'($urandom), w);
        end
        else if (pick < 45)
        begin
            if (tbl_count > 0 && $urandom_range(0, 9) == 0)
                w = stored_word();
            else
                w = random_word();
            send_request(CMD_ADD, pos_t'($urandom), w);
        end
        else if (pick < 60)
            send_request(CMD_MODIFY, pick_position(), random_word());
        else if (pick < 75)
            send_request(CMD_DELETE, pick_position(), random_word());
        else if (pick < 95)
            send_request(CMD_READ, pick_position(), random_word());
        else
            send_request(cmd_t'($urandom_range(int'(CMD_READ) + 1, CMD_CODES - 1)),
                         pos_t'($urandom), random_word());
    endtask

    // ------------------------------------------------------------------------
    // Sink side and checking
    // ------------------------------------------------------------------------

    // The sink drops ready at random. A hold request stops it for a long
    // stretch, counted here, so that the engine backs up into its input.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < PRINT_CAP)
            $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                     $realtime, result_count, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        result_t got;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status         = status_t'(m_axis_tuser);
            got.found_position = m_axis_tdata[POS_W-1:0];
            got.data_out       = m_axis_tdata[POS_W +: ELEMENT_WIDTH];
            got.entry_count    = m_axis_tdata[POS_W + ELEMENT_WIDTH +: POS_W];
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, status", got.status, '0);
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.found_position !== want.found_position)
                    report_mismatch("found_position", got.found_position,
                                    want.found_position);
                if (got.data_out !== want.data_out)
                    report_mismatch("data_out", got.data_out, want.data_out);
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", got.entry_count, want.entry_count);
            end
            result_count++;
        end
    end

    // Ends the run if neither channel moves anything for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles.", WATCHDOG_LIMIT);
                $display("FAIL unsorted_table_engine");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty-table rejects, all-zero and all-one words, duplicates, the
    // highest of several matches, deletes that move the last entry, bad
    // positions up to the top of the field, and the unknown commands.
    task automatic test_directed_corners();
        send_request(CMD_SEARCH, POS_ONE, '0);
        send_request(CMD_READ, '0, '0);
        send_request(CMD_READ, POS_ONE, '0);
        send_request(CMD_MODIFY, POS_ONE, '1);
        send_request(CMD_DELETE, POS_ONE, '0);
        send_request(CMD_ADD, '0, '1);
        send_request(CMD_ADD, '1, '0);
        send_request(CMD_ADD, '0, 64'hA5A5_A5A5_A5A5_A5A5);
        send_request(CMD_ADD, '0, '0);
        send_request(CMD_SEARCH, '0, '1);
        send_request(CMD_SEARCH, '0, '0);
        // Writing a word that is already stored makes a duplicate; the
        // search and the add after it must report the higher position.
        send_request(CMD_MODIFY, pos_t'(3), '1);
        send_request(CMD_SEARCH, '0, '1);
        send_request(CMD_ADD, '0, '1);
        send_request(CMD_READ, pos_t'(3), '0);
        send_request(CMD_READ, pos_t'(4), '0);
        send_request(CMD_READ, '1, '0);
        send_request(CMD_MODIFY, CAP_POS, 64'h5A5A_5A5A_5A5A_5A5A);
        send_request(CMD_DELETE, POS_ONE, '0);
        send_request(CMD_READ, POS_ONE, '0);
        send_request(CMD_DELETE, POS_TWO, '0);
        send_request(CMD_SEARCH, '0, 64'h8000_0000_0000_0001);
        for (int c = int'(CMD_READ) + 1; c < CMD_CODES; c++)
            send_request(cmd_t'(c), pos_t'($urandom), random_word());
        wait_for_drain();
    endtask

    // Random mix with random idling on both sides. Now and then the source
    // pauses until every result is back, and idles before it goes on.
    task automatic test_random_mix();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            random_request();
            if (i % 100 == 99)
            begin
                wait_for_drain();
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        wait_for_drain();
    endtask

    // Both sides run with no idling at all.
    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_steady  = 1'b1;
        for (int i = 0; i < STEADY_ITEMS; i++)
            random_request();
        wait_for_drain();
        tx_idle_en = 1'b1;
        rx_steady  = 1'b0;
    endtask

    // The sink stalls for a long time while the source keeps offering
    // requests, so the engine fills up and drops s_axis_tready.
    task automatic test_output_backpressure();
        tx_idle_en      = 1'b0;
        rx_hold_request = 1'b1;
        for (int i = 0; i < HOLD_ITEMS; i++)
        begin
            if (i % 2 == 0)
                send_request(CMD_READ, pick_position(), '0);
            else
                send_request(CMD_SEARCH, '0, random_word());
        end
        wait_for_drain();
        tx_idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_corners();
        test_random_mix();
        test_steady_stream();
        test_output_backpressure();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests of every kind; %0d results, %0d mismatches.",
                 request_count, result_count, error_count);
        $display("Peak %0d entries; ok %0d, miss %0d, full %0d, duplicate %0d, bad position %0d.",
                 peak_count, status_tally[0], status_tally[1], status_tally[2],
                 status_tally[3], status_tally[4]);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS unsorted_table_engine");
        else
            $display("FAIL unsorted_table_engine");
        $finish;
    end

endmodule

/* filelist.f */
src/ute_pkg.sv
src/ute_ram.sv
src/ute_ctrl.sv
src/unsorted_table_engine.sv
test/tb.sv
